// ===== src/tget_pkg.sv =====
// Package with shared constants and types of the touch gesture event tracker.
package tget_pkg;

   localparam int TRACK_IDS_DEFAULT  = 16;
   localparam int COORD_BITS_DEFAULT = 15;

   localparam logic [15:0] MOVE_THRESHOLD_RESET = 16'd10;
   localparam logic [31:0] HOLD_TIME_RESET      = 32'd500;
   localparam logic [31:0] DEBOUNCE_TIME_RESET  = 32'd0;

   localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_HOLD_TIME      = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE_TIME  = 2'd2;

   localparam logic [1:0] OP_POINT = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   localparam logic [1:0] EV_PRESS   = 2'd0;
   localparam logic [1:0] EV_RELEASE = 2'd1;
   localparam logic [1:0] EV_MOVE    = 2'd2;
   localparam logic [1:0] EV_HOLD    = 2'd3;

   localparam int HOLD_RADIUS_FACTOR = 3;
   localparam int CMP_W              = 36;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         id;
      logic [14:0]        x;
      logic [14:0]        y;
      logic [15:0]        size;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [31:0]        dur;
      logic               last;
   } event_type;

endpackage

// ===== src/touch_gesture_event_tracker.sv =====
// Top level of the touch gesture event tracker.
// A point transfer is taken without a stall and gives no result; the next may follow at once.
// An end-of-frame transfer scans every id twice: an id needing no work passes only the scan state;
// one that is read also passes square, decision (and hold, if it moves and holds), then a flush.
// The input stalls meanwhile. A stop scans every id once; output stalls pause scan and flush.
// Reset clears the settings, flags, state machine and output valid bits; memories keep their contents.
module touch_gesture_event_tracker #(
   parameter int TRACK_IDS  = tget_pkg::TRACK_IDS_DEFAULT,
   parameter int COORD_BITS = tget_pkg::COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_track_id,
   input  logic [14:0] req_pos_x,
   input  logic [14:0] req_pos_y,
   input  logic [15:0] req_contact_area,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [3:0]  rsp_event_id,
   output logic [14:0] rsp_event_x,
   output logic [14:0] rsp_event_y,
   output logic [15:0] rsp_event_size,
   output logic signed [15:0] rsp_delta_x,
   output logic signed [15:0] rsp_delta_y,
   output logic [31:0] rsp_elapsed_ms,
   output logic        rsp_last_event
);

   localparam int ID_W = (TRACK_IDS > 1) ? $clog2(TRACK_IDS) : 1;
   localparam int CB   = COORD_BITS;
   localparam int SQ_W = 2 * CB + 1;
   localparam int CW   = tget_pkg::CMP_W;
   localparam logic [ID_W-1:0] LAST_ID = ID_W'(TRACK_IDS - 1);
   localparam int HOLD_SQ = tget_pkg::HOLD_RADIUS_FACTOR * tget_pkg::HOLD_RADIUS_FACTOR;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SQ    = 3'd2;
   localparam logic [2:0] ST_DEC   = 3'd3;
   localparam logic [2:0] ST_HOLD  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;

   logic [15:0] move_thr_ff;
   logic [31:0] hold_time_ff;
   logic [31:0] deb_time_ff;

   logic [2:0]      state_ff, state_in;
   logic [ID_W-1:0] cnt_ff, cnt_in;
   logic            phase_ff, phase_in;
   logic            stop_ff, stop_in;
   logic [31:0]     now_ff, now_in;

   logic [TRACK_IDS-1:0] active_ff, active_in;
   logic [TRACK_IDS-1:0] deb_ff, deb_in;
   logic [TRACK_IDS-1:0] holddone_ff, holddone_in;
   logic [TRACK_IDS-1:0] relseen_ff, relseen_in;
   logic [TRACK_IDS-1:0] present_ff, present_in;

   logic                 pend_valid_ff, pend_valid_in;
   tget_pkg::event_type  pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   tget_pkg::event_type  out_ff, out_in;

   logic [CB-1:0] mem_px [TRACK_IDS];
   logic [CB-1:0] mem_py [TRACK_IDS];
   logic [15:0]   mem_ps [TRACK_IDS];
   logic [CB-1:0] mem_ox [TRACK_IDS];
   logic [CB-1:0] mem_oy [TRACK_IDS];
   logic [31:0]   mem_pt [TRACK_IDS];
   logic [31:0]   mem_rt [TRACK_IDS];
   logic [CB-1:0] a_px_q, a_py_q, a_ox_q, a_oy_q;
   logic [15:0]   a_ps_q;
   logic [31:0]   a_pt_q, a_rt_q;

   logic [CB-1:0] frm_x [TRACK_IDS];
   logic [CB-1:0] frm_y [TRACK_IDS];
   logic [15:0]   frm_sz [TRACK_IDS];
   logic [CB-1:0] b_x_q, b_y_q;
   logic [15:0]   b_sz_q;

   logic          rd_en;
   logic          wr_track, wr_rel;
   logic          wr_frame;
   logic [ID_W-1:0] point_id;

   logic [31:0]   thr2_ff;
   logic [SQ_W-1:0] sq_move, sq_orig;

   logic          out_free, can_push, emit, flush_push;
   tget_pkg::event_type emit_ev;

   logic          sel;
   logic [2:0]    adv_state;
   logic [ID_W-1:0] adv_cnt;
   logic          adv_phase;

   logic [31:0]   dur;
   logic [31:0]   rel_age;
   logic          deb_new;
   logic          is_move, is_hold;
   logic [CW-1:0] thr2_w, hold2_w;
   logic [CB:0]   diff_x, diff_y;

   tget_sqdist #(.COORD_BITS(CB)) u_sq_move (
      .clock(clock), .ax(b_x_q), .ay(b_y_q), .bx(a_px_q), .by(a_py_q), .dist_ff(sq_move));

   tget_sqdist #(.COORD_BITS(CB)) u_sq_orig (
      .clock(clock), .ax(b_x_q), .ay(b_y_q), .bx(a_ox_q), .by(a_oy_q), .dist_ff(sq_orig));

   always_ff @(posedge clock) begin
      if (reset) begin
         move_thr_ff  <= tget_pkg::MOVE_THRESHOLD_RESET;
         hold_time_ff <= tget_pkg::HOLD_TIME_RESET;
         deb_time_ff  <= tget_pkg::DEBOUNCE_TIME_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tget_pkg::REG_MOVE_THRESHOLD: move_thr_ff  <= csr_data[15:0];
            tget_pkg::REG_HOLD_TIME:      hold_time_ff <= csr_data;
            tget_pkg::REG_DEBOUNCE_TIME:  deb_time_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      thr2_ff <= 32'(move_thr_ff) * 32'(move_thr_ff);
   end

   assign point_id = ID_W'(req_track_id);
   assign wr_frame = (state_ff == ST_IDLE) && req_valid && (req_opcode == tget_pkg::OP_POINT)
                     && (32'(req_track_id) < TRACK_IDS);

   always_ff @(posedge clock) begin
      if (wr_frame) begin
         frm_x[point_id]  <= req_pos_x[CB-1:0];
         frm_y[point_id]  <= req_pos_y[CB-1:0];
         frm_sz[point_id] <= req_contact_area;
      end
      if (rd_en) begin
         b_x_q  <= frm_x[cnt_ff];
         b_y_q  <= frm_y[cnt_ff];
         b_sz_q <= frm_sz[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_track) begin
         mem_px[cnt_ff] <= b_x_q;
         mem_py[cnt_ff] <= b_y_q;
         mem_ps[cnt_ff] <= b_sz_q;
      end
      if (wr_track && !active_ff[cnt_ff]) begin
         mem_ox[cnt_ff] <= b_x_q;
         mem_oy[cnt_ff] <= b_y_q;
         mem_pt[cnt_ff] <= deb_new ? a_rt_q : now_ff;
      end
      if (wr_rel) begin
         mem_rt[cnt_ff] <= now_ff;
      end
      if (rd_en) begin
         a_px_q <= mem_px[cnt_ff];
         a_py_q <= mem_py[cnt_ff];
         a_ps_q <= mem_ps[cnt_ff];
         a_ox_q <= mem_ox[cnt_ff];
         a_oy_q <= mem_oy[cnt_ff];
         a_pt_q <= mem_pt[cnt_ff];
         a_rt_q <= mem_rt[cnt_ff];
      end
   end

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      can_push = !pend_valid_ff || out_free;

      if (stop_ff) begin
         sel = active_ff[cnt_ff];
      end else if (!phase_ff) begin
         sel = active_ff[cnt_ff] && !present_ff[cnt_ff];
      end else begin
         sel = present_ff[cnt_ff];
      end

      adv_cnt   = cnt_ff + 1'b1;
      adv_phase = phase_ff;
      adv_state = ST_SCAN;
      if (cnt_ff == LAST_ID) begin
         adv_cnt = '0;
         if (!phase_ff && !stop_ff) begin
            adv_phase = 1'b1;
         end else begin
            adv_state = ST_FLUSH;
         end
      end

      dur     = now_ff - a_pt_q;
      rel_age = now_ff - a_rt_q;
      deb_new = relseen_ff[cnt_ff] && (deb_time_ff != 32'd0) && (rel_age < deb_time_ff);
      thr2_w  = CW'(thr2_ff);
      hold2_w = thr2_w * CW'(HOLD_SQ);
      is_move = CW'(sq_move) >= thr2_w;
      is_hold = !holddone_ff[cnt_ff] && (dur >= hold_time_ff) && (CW'(sq_orig) < hold2_w);
      diff_x  = {1'b0, b_x_q} - {1'b0, a_px_q};
      diff_y  = {1'b0, b_y_q} - {1'b0, a_py_q};

      emit_ev.kind = tget_pkg::EV_PRESS;
      emit_ev.id   = 4'(cnt_ff);
      emit_ev.x    = 15'(b_x_q);
      emit_ev.y    = 15'(b_y_q);
      emit_ev.size = b_sz_q;
      emit_ev.dx   = '0;
      emit_ev.dy   = '0;
      emit_ev.dur  = dur;
      emit_ev.last = 1'b0;
      emit         = 1'b0;

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      phase_in    = phase_ff;
      stop_in     = stop_ff;
      now_in      = now_ff;
      active_in   = active_ff;
      deb_in      = deb_ff;
      holddone_in = holddone_ff;
      relseen_in  = relseen_ff;
      present_in  = present_ff;
      rd_en       = 1'b0;
      wr_track    = 1'b0;
      wr_rel      = 1'b0;
      flush_push  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (wr_frame) begin
               present_in[point_id] = 1'b1;
            end
            if (req_valid && (req_opcode == tget_pkg::OP_END || req_opcode == tget_pkg::OP_STOP))
            begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               phase_in = 1'b0;
               stop_in  = (req_opcode == tget_pkg::OP_STOP);
               now_in   = req_now_ms;
            end
         end
         ST_SCAN: begin
            if (sel) begin
               rd_en    = 1'b1;
               state_in = ST_SQ;
            end else begin
               state_in = adv_state;
               cnt_in   = adv_cnt;
               phase_in = adv_phase;
            end
         end
         ST_SQ: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (!phase_ff) begin
               emit         = stop_ff || !deb_ff[cnt_ff];
               emit_ev.kind = tget_pkg::EV_RELEASE;
               emit_ev.x    = 15'(a_px_q);
               emit_ev.y    = 15'(a_py_q);
               emit_ev.size = a_ps_q;
            end else if (!active_ff[cnt_ff]) begin
               emit         = !deb_new;
               emit_ev.dur  = '0;
            end else begin
               emit         = is_move || is_hold;
               emit_ev.kind = is_move ? tget_pkg::EV_MOVE : tget_pkg::EV_HOLD;
               if (is_move) begin
                  emit_ev.dx = 16'($signed(diff_x));
                  emit_ev.dy = 16'($signed(diff_y));
               end
            end
            if (emit && !can_push) begin
               emit = 1'b0;
            end else begin
               state_in = adv_state;
               cnt_in   = adv_cnt;
               phase_in = adv_phase;
               if (!phase_ff) begin
                  active_in[cnt_ff] = 1'b0;
                  if (!stop_ff) begin
                     relseen_in[cnt_ff] = 1'b1;
                     wr_rel             = 1'b1;
                  end
               end else if (!active_ff[cnt_ff]) begin
                  active_in[cnt_ff]   = 1'b1;
                  holddone_in[cnt_ff] = 1'b0;
                  deb_in[cnt_ff]      = deb_new;
                  wr_track            = 1'b1;
               end else begin
                  wr_track = is_move;
                  if (is_hold && !is_move) begin
                     holddone_in[cnt_ff] = 1'b1;
                  end
                  if (is_hold && is_move) begin
                     state_in = ST_HOLD;
                     cnt_in   = cnt_ff;
                     phase_in = phase_ff;
                  end
               end
            end
         end
         ST_HOLD: begin
            emit_ev.kind = tget_pkg::EV_HOLD;
            if (can_push) begin
               emit                = 1'b1;
               holddone_in[cnt_ff] = 1'b1;
               state_in            = adv_state;
               cnt_in              = adv_cnt;
               phase_in            = adv_phase;
            end
         end
         ST_FLUSH: begin
            present_in = '0;
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               flush_push = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      if (emit) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_ev;
      end else if (flush_push) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         phase_ff      <= 1'b0;
         stop_ff       <= 1'b0;
         active_ff     <= '0;
         deb_ff        <= '0;
         holddone_ff   <= '0;
         relseen_ff    <= '0;
         present_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         phase_ff      <= phase_in;
         stop_ff       <= stop_in;
         active_ff     <= active_in;
         deb_ff        <= deb_in;
         holddone_ff   <= holddone_in;
         relseen_ff    <= relseen_in;
         present_ff    <= present_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_event_kind  = out_ff.kind;
   assign rsp_event_id    = out_ff.id;
   assign rsp_event_x     = out_ff.x;
   assign rsp_event_y     = out_ff.y;
   assign rsp_event_size  = out_ff.size;
   assign rsp_delta_x     = out_ff.dx;
   assign rsp_delta_y     = out_ff.dy;
   assign rsp_elapsed_ms  = out_ff.dur;
   assign rsp_last_event  = out_ff.last;

endmodule

// ===== src/tget_sqdist.sv =====
// Registered squared Euclidean distance between two points.
module tget_sqdist #(
   parameter int COORD_BITS = tget_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic [COORD_BITS-1:0]   ax,
   input  logic [COORD_BITS-1:0]   ay,
   input  logic [COORD_BITS-1:0]   bx,
   input  logic [COORD_BITS-1:0]   by,
   output logic [2*COORD_BITS:0]   dist_ff
);

   localparam int SW = 2 * COORD_BITS;

   logic [COORD_BITS-1:0]   abs_x;
   logic [COORD_BITS-1:0]   abs_y;
   logic [2*COORD_BITS-1:0] sq_x;
   logic [2*COORD_BITS-1:0] sq_y;
   logic [2*COORD_BITS:0]   dist_in;

   always_comb begin
      abs_x   = (ax >= bx) ? (ax - bx) : (bx - ax);
      abs_y   = (ay >= by) ? (ay - by) : (by - ay);
      sq_x    = SW'(abs_x) * SW'(abs_x);
      sq_y    = SW'(abs_y) * SW'(abs_y);
      dist_in = {1'b0, sq_x} + {1'b0, sq_y};
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the touch gesture event tracker, with its own event predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NIDS = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   class gesture_scoreboard;
      bit [15:0] thr;
      bit [31:0] hold_ms;
      bit [31:0] deb_ms;
      bit        active[NIDS], debouncing[NIDS], hold_done[NIDS], rel_seen[NIDS];
      bit        present[NIDS];
      bit [14:0] pt_x[NIDS], pt_y[NIDS], org_x[NIDS], org_y[NIDS], fx[NIDS], fy[NIDS];
      bit [15:0] pt_size[NIDS], fsize[NIDS];
      bit [31:0] press_at[NIDS], rel_at[NIDS];
      tget_pkg::event_type pending_events[$];
      int        errors, items, seen, kind_count[4];

      function new();
         thr = tget_pkg::MOVE_THRESHOLD_RESET;
         hold_ms = tget_pkg::HOLD_TIME_RESET;
         deb_ms = tget_pkg::DEBOUNCE_TIME_RESET;
         foreach (active[i]) begin
            active[i] = 0; debouncing[i] = 0; hold_done[i] = 0;
            rel_seen[i] = 0; present[i] = 0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         if (idx == tget_pkg::REG_MOVE_THRESHOLD) thr = value[15:0];
         else if (idx == tget_pkg::REG_HOLD_TIME) hold_ms = value;
         else if (idx == tget_pkg::REG_DEBOUNCE_TIME) deb_ms = value;
      endfunction

      function longint dist2(bit [14:0] ax, bit [14:0] ay, bit [14:0] bx, bit [14:0] by);
         longint dx, dy;
         dx = longint'(ax) - longint'(bx);
         dy = longint'(ay) - longint'(by);
         return dx * dx + dy * dy;
      endfunction

      function tget_pkg::event_type mk(logic [1:0] k, int id, bit [14:0] x, bit [14:0] y,
                                       bit [15:0] sz, int dx, int dy, bit [31:0] dur);
         tget_pkg::event_type e;
         e.kind = k; e.id = id[3:0]; e.x = x; e.y = y; e.size = sz;
         e.dx = dx[15:0]; e.dy = dy[15:0]; e.dur = dur; e.last = 1'b0;
         return e;
      endfunction

      function void note_input(logic [1:0] op, logic [3:0] id, logic [14:0] x,
                               logic [14:0] y, logic [15:0] sz, logic [31:0] now);
         tget_pkg::event_type evs[$];
         longint t2, h2;
         bit [31:0] dur;
         bit deb;
         items++;
         if (op == tget_pkg::OP_POINT) begin
            present[id] = 1; fx[id] = x; fy[id] = y; fsize[id] = sz;
            return;
         end
         if (op == tget_pkg::OP_END) begin
            t2 = longint'(thr) * longint'(thr);
            h2 = t2 * tget_pkg::HOLD_RADIUS_FACTOR * tget_pkg::HOLD_RADIUS_FACTOR;
            for (int i = 0; i < NIDS; i++) begin
               if (!active[i] || present[i]) continue;
               rel_seen[i] = 1;
               rel_at[i] = now;
               if (!debouncing[i])
                  evs = {evs, mk(tget_pkg::EV_RELEASE, i, pt_x[i], pt_y[i], pt_size[i], 0, 0,
                                 now - press_at[i])};
               active[i] = 0;
            end
            for (int i = 0; i < NIDS; i++) begin
               if (!present[i]) continue;
               if (!active[i]) begin
                  deb = rel_seen[i] && deb_ms != 0 && (now - rel_at[i]) < deb_ms;
                  active[i] = 1; hold_done[i] = 0; debouncing[i] = deb;
                  pt_x[i] = fx[i]; pt_y[i] = fy[i]; pt_size[i] = fsize[i];
                  org_x[i] = fx[i]; org_y[i] = fy[i];
                  press_at[i] = deb ? rel_at[i] : now;
                  if (!deb)
                     evs = {evs, mk(tget_pkg::EV_PRESS, i, fx[i], fy[i], fsize[i], 0, 0, 0)};
               end else begin
                  dur = now - press_at[i];
                  if (dist2(fx[i], fy[i], pt_x[i], pt_y[i]) >= t2) begin
                     evs = {evs, mk(tget_pkg::EV_MOVE, i, fx[i], fy[i], fsize[i],
                                    int'(fx[i]) - int'(pt_x[i]),
                                    int'(fy[i]) - int'(pt_y[i]), dur)};
                     pt_x[i] = fx[i]; pt_y[i] = fy[i]; pt_size[i] = fsize[i];
                  end
                  if (!hold_done[i] && dur >= hold_ms &&
                      dist2(fx[i], fy[i], org_x[i], org_y[i]) < h2) begin
                     hold_done[i] = 1;
                     evs = {evs, mk(tget_pkg::EV_HOLD, i, fx[i], fy[i], fsize[i], 0, 0, dur)};
                  end
               end
            end
         end else if (op == tget_pkg::OP_STOP) begin
            for (int i = 0; i < NIDS; i++) begin
               if (active[i])
                  evs = {evs, mk(tget_pkg::EV_RELEASE, i, pt_x[i], pt_y[i], pt_size[i], 0, 0,
                                 now - press_at[i])};
               active[i] = 0;
            end
         end else begin
            return;
         end
         foreach (present[i]) present[i] = 0;
         if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
         pending_events = {pending_events, evs};
      endfunction

      function void check_result(tget_pkg::event_type got);
         tget_pkg::event_type want;
         if (pending_events.size() == 0) begin
            $error("event transfer with no event expected: kind %0d id %0d", got.kind, got.id);
            errors++;
            return;
         end
         want = pending_events.pop_front();
         seen++;
         kind_count[want.kind]++;
         if (got.kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, got.kind); errors++;
         end
         if (got.id !== want.id) begin
            $error("event_id: expected %0d, got %0d", want.id, got.id); errors++;
         end
         if (got.x !== want.x) begin
            $error("event_x: expected %0d, got %0d", want.x, got.x); errors++;
         end
         if (got.y !== want.y) begin
            $error("event_y: expected %0d, got %0d", want.y, got.y); errors++;
         end
         if (got.size !== want.size) begin
            $error("event_size: expected %0d, got %0d", want.size, got.size); errors++;
         end
         if (got.dx !== want.dx) begin
            $error("delta_x: expected %0d, got %0d", want.dx, got.dx); errors++;
         end
         if (got.dy !== want.dy) begin
            $error("delta_y: expected %0d, got %0d", want.dy, got.dy); errors++;
         end
         if (got.dur !== want.dur) begin
            $error("elapsed_ms: expected %0d, got %0d", want.dur, got.dur); errors++;
         end
         if (got.last !== want.last) begin
            $error("last_event: expected %0d, got %0d", want.last, got.last); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_track_id = '0;
   logic [14:0] req_pos_x = '0;
   logic [14:0] req_pos_y = '0;
   logic [15:0] req_contact_area = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [3:0]  rsp_event_id;
   logic [14:0] rsp_event_x, rsp_event_y;
   logic [15:0] rsp_event_size;
   logic signed [15:0] rsp_delta_x, rsp_delta_y;
   logic [31:0] rsp_elapsed_ms;
   logic        rsp_last_event;

   gesture_scoreboard sb = new();
   int  cycles;
   bit  quiet;
   bit  hold_req;
   bit [31:0] clock_ms;
   bit [14:0] last_x[NIDS], last_y[NIDS];
   bit  touching[NIDS];

   touch_gesture_event_tracker dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d events outstanding", sb.pending_events.size());
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      tget_pkg::event_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_event_kind, rsp_event_id, rsp_event_x, rsp_event_y, rsp_event_size,
                 rsp_delta_x, rsp_delta_y, rsp_elapsed_ms, rsp_last_event};
         sb.check_result(got);
      end
   end

   // Receiver back-pressure, with one long hold-off on request.
   initial begin
      int len;
      bit held;
      held = 0;
      forever begin
         if (hold_req && !held) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            held = 1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                               : int'($urandom_range(1, 3));
            repeat (len) @(posedge clock);
         end
      end
   end

   task automatic send(logic [1:0] op, logic [3:0] id, logic [14:0] x, logic [14:0] y,
                       logic [15:0] sz, logic [31:0] now);
      int gap;
      int r;
      r = int'($urandom_range(0, 99));
      gap = quiet ? 0 : (r < 60 ? 0 : (r < 90 ? int'($urandom_range(1, 3))
                                              : int'($urandom_range(5, 30))));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_track_id <= id;
      req_pos_x <= x;
      req_pos_y <= y;
      req_contact_area <= sz;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      sb.note_input(op, id, x, y, sz, now);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_events.size() != 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   function automatic bit [14:0] nudge(bit [14:0] v, int span);
      int n;
      n = int'(v) + int'($urandom_range(0, 2 * span)) - span;
      if (n < 0) n = 0;
      if (n > 32767) n = 32767;
      return n[14:0];
   endfunction

   task automatic random_frames(int count, int span, int step_ms);
      int sent;
      bit [3:0] id;
      sent = 0;
      while (sent < count) begin
         clock_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, step_ms);
         case ($urandom_range(0, 19))
            0: begin
               send(tget_pkg::OP_STOP, 4'($urandom), 15'($urandom), 15'($urandom),
                    16'($urandom), clock_ms);
               foreach (touching[i]) touching[i] = 0;
               sent++;
            end
            1: begin
               send(OP_UNUSED, 4'($urandom), 15'($urandom), 15'($urandom), 16'($urandom),
                    $urandom);
               send(tget_pkg::OP_POINT, 4'($urandom), 15'($urandom), 15'($urandom),
                    16'($urandom), $urandom);
               sent++;
            end
            default: begin
               foreach (touching[i])
                  if ($urandom_range(0, 5) == 0) touching[i] = !touching[i];
               for (int i = 0; i < NIDS; i++) begin
                  if (!touching[i]) continue;
                  id = 4'(i);
                  if ($urandom_range(0, 15) == 0) begin
                     last_x[i] = 15'($urandom);
                     last_y[i] = 15'($urandom);
                  end else begin
                     last_x[i] = nudge(last_x[i], span);
                     last_y[i] = nudge(last_y[i], span);
                  end
                  send(tget_pkg::OP_POINT, id, last_x[i], last_y[i], 16'($urandom), $urandom);
                  sent++;
                  if ($urandom_range(0, 9) == 0) begin
                     send(tget_pkg::OP_POINT, id, 15'($urandom), 15'($urandom),
                          16'($urandom), $urandom);
                     last_x[i] = req_pos_x;
                     last_y[i] = req_pos_y;
                  end
               end
               send(tget_pkg::OP_END, 4'($urandom), 15'($urandom), 15'($urandom),
                    16'($urandom), clock_ms);
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: presses, overwrite of a repeated id, move, hold, release, stop.
      send(tget_pkg::OP_POINT, 4'd0, 15'd0, 15'd0, 16'd0, 32'd0);
      send(tget_pkg::OP_POINT, 4'd15, 15'h7FFF, 15'h7FFF, 16'hFFFF, 32'hFFFFFFFF);
      send(tget_pkg::OP_POINT, 4'd3, 15'd100, 15'd200, 16'd5, 32'd0);
      send(tget_pkg::OP_POINT, 4'd3, 15'd300, 15'd400, 16'd6, 32'd0);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd1000);
      send(tget_pkg::OP_POINT, 4'd0, 15'd20, 15'd0, 16'd1, 32'd0);
      send(tget_pkg::OP_POINT, 4'd15, 15'h7FFF, 15'h7FFF, 16'hFFFF, 32'd0);
      send(tget_pkg::OP_POINT, 4'd3, 15'd300, 15'd400, 16'd6, 32'd0);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd1100);
      send(OP_UNUSED, 4'hF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 32'hFFFFFFFF);
      send(tget_pkg::OP_POINT, 4'd0, 15'd25, 15'd3, 16'd2, 32'd0);
      send(tget_pkg::OP_POINT, 4'd15, 15'h7FFE, 15'h7FFF, 16'hFFFF, 32'd0);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd1700);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd1800);
      send(tget_pkg::OP_POINT, 4'd5, 15'd7, 15'd9, 16'd11, 32'd0);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'h0);
      send(tget_pkg::OP_STOP, 4'd0, 15'd0, 15'd0, 16'd0, 32'hFFFFFFFF);
      send(tget_pkg::OP_STOP, 4'd0, 15'd0, 15'd0, 16'd0, 32'd5);
      settle();

      // Debouncing window: a quick re-touch stays silent and its release is hidden.
      write_reg(tget_pkg::REG_MOVE_THRESHOLD, 32'd3);
      write_reg(tget_pkg::REG_HOLD_TIME, 32'd40);
      write_reg(tget_pkg::REG_DEBOUNCE_TIME, 32'd30);
      send(tget_pkg::OP_POINT, 4'd7, 15'd50, 15'd50, 16'd9, 32'd0);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd2000);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd2010);
      send(tget_pkg::OP_POINT, 4'd7, 15'd51, 15'd50, 16'd9, 32'd0);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd2020);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd2030);
      send(tget_pkg::OP_POINT, 4'd7, 15'd51, 15'd50, 16'd9, 32'd0);
      send(tget_pkg::OP_END, 4'd0, 15'd0, 15'd0, 16'd0, 32'd2100);

      clock_ms = $urandom;
      foreach (touching[i]) touching[i] = 0;
      hold_req = 1;
      quiet = 1;
      random_frames(15, 4, 20);
      quiet = 0;
      random_frames(15, 4, 20);
      settle();

      write_reg(tget_pkg::REG_MOVE_THRESHOLD, 32'd0);
      write_reg(tget_pkg::REG_HOLD_TIME, 32'd0);
      write_reg(tget_pkg::REG_DEBOUNCE_TIME, 32'd0);
      random_frames(20, 3, 10);
      settle();

      write_reg(tget_pkg::REG_MOVE_THRESHOLD, 32'hFFFF);
      write_reg(tget_pkg::REG_HOLD_TIME, 32'hFFFFFFFF);
      write_reg(tget_pkg::REG_DEBOUNCE_TIME, 32'hFFFFFFFF);
      random_frames(15, 2000, 100);
      settle();

      write_reg(tget_pkg::REG_MOVE_THRESHOLD, 32'd10);
      write_reg(tget_pkg::REG_HOLD_TIME, 32'd150);
      write_reg(tget_pkg::REG_DEBOUNCE_TIME, 32'd1);
      quiet = 1;
      random_frames(12, 12, 60);
      quiet = 0;
      random_frames(12, 12, 60);
      settle();

      $display("%0d input transfers checked against %0d events", sb.items, sb.seen);
      $display("press %0d, release %0d, move %0d, hold %0d, over five register settings",
               sb.kind_count[tget_pkg::EV_PRESS], sb.kind_count[tget_pkg::EV_RELEASE],
               sb.kind_count[tget_pkg::EV_MOVE], sb.kind_count[tget_pkg::EV_HOLD]);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
